/* rtl/aes_block_cipher_top_assert.svh */
// Assertion macros for the cipher block.
`ifndef AES_BLOCK_CIPHER_TOP_ASSERT_SVH
`define AES_BLOCK_CIPHER_TOP_ASSERT_SVH
`define AES_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define AES_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/aes_pkg.sv */
package aes_pkg;

  typedef struct packed {
    logic        action;
    logic [63:0] data_in_high;
    logic [63:0] data_in_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] data_out_high;
    logic [63:0] data_out_low;
  } aes_out_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] index;
    logic [63:0] data;
  } aes_cfg_t;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_SIZE = 3'd4;

  localparam int ROUND_IDX_W = 4;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] bs;
    r = 8'h01;
    bs = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, bs);
      bs = gmul(bs, bs);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] x);
    isbox_calc = ginv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t mk_sbox(input logic inv);
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    mk_sbox = t;
  endfunction

  localparam sbox_arr_t SBOX  = mk_sbox(1'b0);
  localparam sbox_arr_t ISBOX = mk_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    mix_word = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    inv_mix_word = {
      gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
      gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
      gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
      gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
  endfunction

endpackage

/* rtl/aes_round.sv */
module aes_round
  import aes_pkg::*;
(
  input  logic         inv,
  input  logic         last,
  input  logic [127:0] st,
  input  logic [127:0] rk,
  output logic [127:0] res
);

  logic [7:0]  s [16];
  logic [7:0]  t [16];
  logic [127:0] m;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        if (inv) begin
          t[k + 4*((c + k) & 3)] = ISBOX[s[k + 4*c]];
        end else begin
          t[k + 4*c] = SBOX[s[k + 4*((c + k) & 3)]];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127 - 32*c -: 32] = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      if (!last) begin
        m[127 - 32*c -: 32] = inv ? inv_mix_word(m[127 - 32*c -: 32])
                                  : mix_word(m[127 - 32*c -: 32]);
      end
    end
    res = m ^ rk;
  end

endmodule

/* rtl/aes_keyexp.sv */
module aes_keyexp
  import aes_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [255:0]           key,
  input  logic [1:0]             key_size,
  output logic                   done,
  output logic [3:0]             nr,
  input  logic [ROUND_IDX_W-1:0] rd_round,
  input  logic                   rd_inv,
  output logic [127:0]           rd_key
);

  localparam logic [1:0] KS_IDLE = 2'd0;
  localparam logic [1:0] KS_FWD  = 2'd1;
  localparam logic [1:0] KS_INV  = 2'd2;

  logic [1:0]  state;
  logic [5:0]  i;
  logic [2:0]  j;
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [7:0]  rc;
  logic [31:0] win [8];
  logic [31:0] temp;
  logic [31:0] neww;
  logic [127:0] fwd [15];
  logic [127:0] invk [15];
  logic [3:0]  r;
  logic [3:0]  rinv;

  always_comb begin
    case (key_size)
      2'd0:    begin nk = 4'd4; nr = 4'd10; end
      2'd1:    begin nk = 4'd6; nr = 4'd12; end
      default: begin nk = 4'd8; nr = 4'd14; end
    endcase
    total = 6'(4 * (nr + 1));
    temp = win[3'(nk - 4'd1)];
    if (j == 3'd0) begin
      temp = sub_word({temp[23:0], temp[31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && j == 3'd4) begin
      temp = sub_word(temp);
    end
    neww = win[0] ^ temp;
    rinv = nr - r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_IDLE;
      done <= 1'b0;
    end else begin
      case (state)
        KS_IDLE: begin
          if (start) begin
            for (int k = 0; k < 8; k++) begin
              win[k] <= key[255 - 32*k -: 32];
            end
            for (int k = 0; k < 8; k++) begin
              if (4'(k) < nk) fwd[k >> 2][127 - 32*(k & 3) -: 32] <= key[255 - 32*k -: 32];
            end
            i <= 6'(nk);
            j <= 3'd0;
            rc <= 8'h01;
            done <= 1'b0;
            state <= KS_FWD;
          end
        end
        KS_FWD: begin
          fwd[i[5:2]][127 - 32*i[1:0] -: 32] <= neww;
          for (int k = 0; k < 7; k++) begin
            win[k] <= (4'(k) == nk - 4'd1) ? neww : win[k + 1];
          end
          if (nk == 4'd8) win[7] <= neww;
          if (j == 3'd0) rc <= xt(rc);
          j <= (4'(j) + 4'd1 == nk) ? 3'd0 : j + 3'd1;
          i <= i + 6'd1;
          if (i + 6'd1 == total) begin
            r <= 4'd0;
            state <= KS_INV;
          end
        end
        KS_INV: begin
          for (int c = 0; c < 4; c++) begin
            invk[r][127 - 32*c -: 32] <= (r == 4'd0 || r == nr)
              ? fwd[rinv][127 - 32*c -: 32] : inv_mix_word(fwd[rinv][127 - 32*c -: 32]);
          end
          r <= r + 4'd1;
          if (r == nr) begin
            done <= 1'b1;
            state <= KS_IDLE;
          end
        end
        default: state <= KS_IDLE;
      endcase
    end
  end

  always_comb begin
    rd_key = rd_inv ? invk[rd_round] : fwd[rd_round];
  end

endmodule

/* rtl/aes_block_cipher_top.sv */
// AES block cipher, FIPS-197, 128/192/256-bit keys.
// Requests come in on in_valid/in_stall with payload in_data (action, block).
// Results leave on out_valid/out_stall with payload out_data.
// The key sits in five registers written over cfg_valid/cfg_ready with
// cfg_index 0..4 (key words 0..3, key size); a write to one marks the key stale.
// cfg_ready is high only while no request is in progress.
// The first request after a write first expands the key: the derived key
// words in turn (40, 46 or 52), then the inverse round keys (11, 13 or 15),
// before handing over to the round unit.
// A block then passes through the single round unit, one round per cycle:
// the initial key addition, then Nr rounds, the last without MixColumns.
// It is then loaded into the output register once that is free, and only
// then is a new request taken.
// in_stall is high while a request is in progress. A result held by
// out_stall stays on out_data; only a finished block behind it waits.
// Reset (rst, synchronous) clears control state and marks the key stale;
// key registers reset to zero.
module aes_block_cipher_top
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  aes_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output aes_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]   state;
  logic [255:0] key;
  logic [1:0]   key_size;
  logic         keys_ready;
  logic         inv;
  logic [127:0] st;
  logic [3:0]   r;
  logic         ks_start;
  logic         ks_done;
  logic [3:0]   nr;
  logic [127:0] rk;
  logic [127:0] rnd;
  logic [3:0]   rd_round;
  aes_out_t     out_reg;
  logic         out_full;
  logic         out_load;

  assign cfg_ready = (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);
  assign out_valid = out_full;
  assign out_load = (state == ST_OUT) && (!out_full || !out_stall);
  assign ks_start = (state == ST_IDLE) && in_valid && !keys_ready;
  assign rd_round = (state == ST_RUN) ? r : 4'd0;

  aes_keyexp u_keyexp (
    .clk(clk), .rst(rst), .start(ks_start), .key(key), .key_size(key_size),
    .done(ks_done), .nr(nr), .rd_round(rd_round), .rd_inv(inv), .rd_key(rk)
  );

  aes_round u_round (
    .inv(inv), .last(r == nr), .st(st), .rk(rk), .res(rnd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      key_size <= 2'd0;
      keys_ready <= 1'b0;
      out_full <= 1'b0;
      state <= ST_IDLE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0: begin key[255:192] <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY1: begin key[191:128] <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY2: begin key[127:64]  <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY3: begin key[63:0]    <= cfg_data; keys_ready <= 1'b0; end
          REG_SIZE: begin key_size <= cfg_data[1:0]; keys_ready <= 1'b0; end
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            inv <= in_data.action;
            st <= {in_data.data_in_high, in_data.data_in_low};
            r <= 4'd0;
            state <= keys_ready ? ST_RUN : ST_KEY;
          end
        end
        ST_KEY: begin
          if (ks_done && !ks_start) begin
            keys_ready <= 1'b1;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          st <= (r == 4'd0) ? (st ^ rk) : rnd;
          r <= r + 4'd1;
          if (r == nr) state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_reg <= st;
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  assign out_data = out_reg;

endmodule

/* rtl/aes_block_cipher_checker.sv */
`include "aes_block_cipher_top_assert.svh"
module aes_block_cipher_props
  import aes_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input aes_out_t out_data
);

  `AES_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `AES_ASSERT_IMP(a_known, clk, rst, 1'b1, !$isunknown({in_stall, out_valid}))
  `AES_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind aes_block_cipher_top aes_block_cipher_props u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
